// ----- hw/rtl/iirfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IIR frequency response package
// Shared constants, operation codes, register indexes and the status type of
// the iterative arithmetic units.
// ----------------------------------------------------------------------------
package iirfr_pkg;

    localparam int DEFAULT_MAX_TAPS = 16;

    // CORDIC rotation steps and the width of the step counter.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_IW    = 5;

    // Start value of x: the inverse CORDIC gain in Q2.30.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // One in Q.27 and the component clamp bound.
    localparam logic signed [63:0] ONE_Q27  = 64'sd134217728;
    localparam logic signed [63:0] COMP_MAX = 64'sd2147483647;

    // Function codes of an input transaction.
    localparam logic [1:0] FUNC_LOAD_FF = 2'd0;
    localparam logic [1:0] FUNC_LOAD_FB = 2'd1;
    localparam logic [1:0] FUNC_EVAL    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [1:0] REG_FREQ_MODE   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd2;

    // Status of an iterative unit: busy while it steps, done for one cycle.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [CORDIC_IW-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/iirfr_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IIR frequency response CORDIC
// Iterative rotation-mode CORDIC, one step per cycle, giving cosine and sine
// in Q2.30 of a phase given as a 32-bit fraction of a turn.
// ----------------------------------------------------------------------------
module iirfr_cordic
    import iirfr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic        [31:0] phase,
    output logic signed      [31:0] cos_out,
    output logic signed      [31:0] sin_out,
    output unit_stat_t              stat
);

    logic signed [33:0]    x_reg, y_reg, z_reg;
    logic [CORDIC_IW-1:0]  iter_reg;
    logic                  flip_reg;
    logic                  busy_reg, done_reg;

    logic        flip;
    logic [31:0] folded;
    logic [31:0] quarter;

    // Fold the phase into [-1/4, 1/4) turn; a half-turn fold negates both.
    assign quarter = phase + 32'h4000_0000;
    assign flip    = quarter[31];
    assign folded  = flip ? (phase + 32'h8000_0000) : phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= {{2{folded[31]}}, folded};
                flip_reg <= flip;
                iter_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - (y_reg >>> iter_reg);
                    y_reg <= y_reg + (x_reg >>> iter_reg);
                    z_reg <= z_reg - $signed({2'b00, atan_turn(iter_reg)});
                end else begin
                    x_reg <= x_reg + (y_reg >>> iter_reg);
                    y_reg <= y_reg - (x_reg >>> iter_reg);
                    z_reg <= z_reg + $signed({2'b00, atan_turn(iter_reg)});
                end
                if (iter_reg == CORDIC_IW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    assign cos_out   = flip_reg ? 32'(-x_reg) : x_reg[31:0];
    assign sin_out   = flip_reg ? 32'(-y_reg) : y_reg[31:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/iirfr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IIR frequency response divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module iirfr_div
    import iirfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic      [63:0] quotient,
    output unit_stat_t       stat
);

    logic [63:0] dvd_reg, quo_reg;
    logic [31:0] rem_reg, dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;

    logic [32:0] rem_shift, rem_sub;
    logic        fits;

    assign rem_shift = {rem_reg, dvd_reg[63]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[31:0] : rem_shift[31:0];
                quo_reg <= {quo_reg[62:0], fits};
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/iirfr_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IIR frequency response square root
// Digit-by-digit floor square root of a 64-bit value, one result bit per
// cycle.
// ----------------------------------------------------------------------------
module iirfr_isqrt
    import iirfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root,
    output unit_stat_t       stat
);

    logic [63:0] v_reg, r_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;

    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= radicand;
                r_reg    <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root      = r_reg[31:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/iir_frequency_response_magnitude_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IIR frequency response magnitude core
// Holds feed-forward and feed-back coefficient tables and evaluates the gain
// magnitude of the filter at one frequency per evaluate transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         tdata: func, index, coef, freq           tvalid/tready
//  m_axis    out        tdata: magnitude; tuser: status          tvalid/tready
//  cfg       in         cfg_index, cfg_wdata                     cfg_wr_en
//
// An evaluate transaction is paced by the 24-step CORDIC run once per tap,
// the 64-step shared divider (phase and final quotient) and two 32-step
// square roots.
// aresetn is synchronous and active low; it clears control state and the
// configuration registers, but not the coefficient tables.
// s_axis_tready is high only while the sequencer is idle. A finished result
// waits in the output register while the next transaction is accepted; a
// later evaluate holds in its last step until that register is free.
// ----------------------------------------------------------------------------
module iir_frequency_response_magnitude_core
    import iirfr_pkg::*;
#(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input transactions.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // From bit 0: func[1:0], index[5:2], coef[37:6], freq[69:38], zero fill.
    input  wire logic [71:0] s_axis_tdata,
    // Result transactions.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // From bit 0: magnitude[31:0].
    output logic      [31:0] m_axis_tdata,
    // From bit 0: status[0].
    output logic       [0:0] m_axis_tuser,
    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic  [1:0] cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE_DIV,
        ST_TAP_START,
        ST_TRIG_WAIT,
        ST_MUL,
        ST_ACC,
        ST_SHRINK,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_SQRT_WAIT,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // Input fields.
    logic        [1:0]  in_func;
    logic        [3:0]  in_index;
    logic signed [31:0] in_coef;
    logic        [31:0] in_freq;

    assign in_func  = s_axis_tdata[1:0];
    assign in_index = s_axis_tdata[5:2];
    assign in_coef  = s_axis_tdata[37:6];
    assign in_freq  = s_axis_tdata[69:38];

    // Configuration registers.
    logic [4:0]  tap_count_reg;
    logic        freq_mode_reg;
    logic [23:0] sample_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg   <= 5'd1;
            freq_mode_reg   <= 1'b0;
            sample_rate_reg <= 24'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TAP_COUNT:   tap_count_reg   <= cfg_wdata[4:0];
                REG_FREQ_MODE:   freq_mode_reg   <= cfg_wdata[0];
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Sequencer state.
    state_t             state_reg;
    logic [CNT_W-1:0]   taps_reg, tap_reg;
    logic [1:0]         k_reg;
    logic               sel_reg;
    logic [31:0]        phase_reg, tap_phase_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [31:0] b_rd_reg, a_rd_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] nr_reg, ni_reg, dr_reg, di_reg;
    logic signed [31:0] nrc_reg, nic_reg, drc_reg, dic_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        nmag_reg;
    logic [31:0]        mag_reg;
    logic               sat_reg;
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic               m_user_reg;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Coefficient tables. Loads beyond the table are dropped.
    logic signed [31:0] ff_mem [MAX_TAPS];
    logic signed [31:0] fb_mem [MAX_TAPS];
    logic               idx_ok;

    assign idx_ok = 32'(in_index) < MAX_TAPS;

    always_ff @(posedge aclk) begin
        if (accept && idx_ok && (in_func == FUNC_LOAD_FF)) begin
            ff_mem[IDX_W'(in_index)] <= in_coef;
        end
        if (accept && idx_ok && (in_func == FUNC_LOAD_FB)) begin
            fb_mem[IDX_W'(in_index)] <= in_coef;
        end
        if (state_reg == ST_TAP_START) begin
            b_rd_reg <= ff_mem[tap_reg[IDX_W-1:0]];
            a_rd_reg <= fb_mem[tap_reg[IDX_W-1:0]];
        end
    end

    // Tap count as used: zero counts as one, large values clamp to the table.
    logic [CNT_W-1:0] taps_used;
    always_comb begin
        if (tap_count_reg == 5'd0) begin
            taps_used = CNT_W'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_used = CNT_W'(MAX_TAPS);
        end else begin
            taps_used = CNT_W'(tap_count_reg);
        end
    end

    // Shared units.
    logic               cordic_start;
    logic signed [31:0] cordic_cos, cordic_sin;
    unit_stat_t         cordic_stat;

    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic [63:0]        div_quotient;
    unit_stat_t         div_stat;

    logic               sqrt_start;
    logic [31:0]        sqrt_root;
    unit_stat_t         sqrt_stat;

    logic               eval_hz;
    logic [23:0]        fs_used;

    assign eval_hz      = accept && (in_func == FUNC_EVAL) && !freq_mode_reg;
    assign fs_used      = (sample_rate_reg == 24'd0) ? 24'd1 : sample_rate_reg;
    assign cordic_start = (state_reg == ST_TAP_START);
    assign sqrt_start   = (state_reg == ST_SQ_C);

    // The divider serves the hertz-to-phase conversion and the final ratio.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            div_start    = eval_hz;
            div_dividend = {16'd0, in_freq, 16'd0};
            div_divisor  = {8'd0, fs_used};
        end else begin
            div_start    = (state_reg == ST_SQRT_WAIT) && sqrt_stat.done && sel_reg
                           && (sqrt_root != 32'd0);
            div_dividend = {8'd0, nmag_reg, 24'd0};
            div_divisor  = sqrt_root;
        end
    end

    iirfr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .phase   (tap_phase_reg),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin),
        .stat    (cordic_stat)
    );

    iirfr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    iirfr_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_reg + 64'(prod_reg)),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // Shared multiplier: the four tap products, then the squares of the
    // clamped components.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_SQ_A: begin
                mul_a = sel_reg ? drc_reg : nrc_reg;
                mul_b = mul_a;
            end
            ST_SQ_B: begin
                mul_a = sel_reg ? dic_reg : nic_reg;
                mul_b = mul_a;
            end
            default: begin
                mul_a = k_reg[1] ? a_rd_reg : b_rd_reg;
                mul_b = k_reg[0] ? sin_reg : cos_reg;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Product back to Q.27 with floor.
    logic signed [63:0] term;
    assign term = prod_reg >>> 30;

    // Component to Q.23 and clamped; the top bit flags the clamp.
    function automatic logic [32:0] shrink(input logic signed [63:0] v);
        logic signed [63:0] s;
        logic [32:0]        r;
        s = v >>> 4;
        if (s > COMP_MAX) begin
            r = {1'b1, COMP_MAX[31:0]};
        end else if (s < -COMP_MAX) begin
            r = {1'b1, 32'(-COMP_MAX)};
        end else begin
            r = {1'b0, s[31:0]};
        end
        return r;
    endfunction

    logic [32:0] sh_nr, sh_ni, sh_dr, sh_di;
    assign sh_nr = shrink(nr_reg);
    assign sh_ni = shrink(ni_reg);
    assign sh_dr = shrink(dr_reg);
    assign sh_di = shrink(di_reg);

    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tap_reg     <= '0;
            k_reg       <= '0;
            sel_reg     <= 1'b0;
        end else begin
            // In the output step the register is refilled instead.
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (in_func == FUNC_EVAL)) begin
                        taps_reg      <= taps_used;
                        tap_reg       <= '0;
                        k_reg         <= '0;
                        sel_reg       <= 1'b0;
                        sat_reg       <= 1'b0;
                        tap_phase_reg <= '0;
                        nr_reg        <= '0;
                        ni_reg        <= '0;
                        dr_reg        <= ONE_Q27;
                        di_reg        <= '0;
                        phase_reg     <= in_freq;
                        state_reg     <= freq_mode_reg ? ST_TAP_START : ST_PHASE_DIV;
                    end
                end
                ST_PHASE_DIV: begin
                    if (div_stat.done) begin
                        phase_reg <= div_quotient[31:0];
                        state_reg <= ST_TAP_START;
                    end
                end
                ST_TAP_START: begin
                    state_reg <= ST_TRIG_WAIT;
                end
                ST_TRIG_WAIT: begin
                    if (cordic_stat.done) begin
                        cos_reg   <= cordic_cos;
                        sin_reg   <= cordic_sin;
                        k_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    case (k_reg)
                        2'd0: nr_reg <= nr_reg + term;
                        2'd1: ni_reg <= ni_reg - term;
                        2'd2: if (tap_reg != '0) dr_reg <= dr_reg + term;
                        2'd3: if (tap_reg != '0) di_reg <= di_reg - term;
                        default: ;
                    endcase
                    if (k_reg == 2'd3) begin
                        tap_phase_reg <= tap_phase_reg + phase_reg;
                        tap_reg       <= tap_reg + 1'b1;
                        state_reg     <= (tap_reg + 1'b1 == taps_reg) ? ST_SHRINK
                                                                      : ST_TAP_START;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SHRINK: begin
                    nrc_reg   <= sh_nr[31:0];
                    nic_reg   <= sh_ni[31:0];
                    drc_reg   <= sh_dr[31:0];
                    dic_reg   <= sh_di[31:0];
                    sat_reg   <= sh_nr[32] | sh_ni[32] | sh_dr[32] | sh_di[32];
                    state_reg <= ST_SQ_A;
                end
                ST_SQ_A: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_B;
                end
                ST_SQ_B: begin
                    sum_reg   <= 64'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_C;
                end
                ST_SQ_C: begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_stat.done) begin
                        if (!sel_reg) begin
                            nmag_reg  <= sqrt_root;
                            sel_reg   <= 1'b1;
                            state_reg <= ST_SQ_A;
                        end else if (sqrt_root == 32'd0) begin
                            mag_reg   <= 32'hFFFF_FFFF;
                            sat_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV_WAIT;
                        end
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        if (div_quotient[63:32] != 32'd0) begin
                            mag_reg <= 32'hFFFF_FFFF;
                            sat_reg <= 1'b1;
                        end else begin
                            mag_reg <= div_quotient[31:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= mag_reg;
                        m_user_reg  <= sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

`ifndef SYNTHESIS
    // The divider and the square root unit are never in use at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_stat.busy && sqrt_stat.busy))
        else $error("divider and square root busy together");

    // A CORDIC result only arrives while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_stat.done |-> (state_reg == ST_TRIG_WAIT))
        else $error("CORDIC result outside its wait step");

    // While a transaction can be accepted, no arithmetic unit is still stepping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !(cordic_stat.busy || div_stat.busy || sqrt_stat.busy))
        else $error("ready while an arithmetic unit is busy");

    // The tap walk never passes the tap count in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP_START) |-> (tap_reg < taps_reg))
        else $error("tap index beyond tap count");
`endif

endmodule
`default_nettype wire
